### rtl/kdr_pkg.sv
// ----------------------------------------------------------------------------
// kdr_pkg: shared types and constants for the kd-tree radius search
// Request and result structures, operation codes and store sizes.
// ----------------------------------------------------------------------------
package kdr_pkg;

	localparam int PT_AW    = 12;   // point / index store address bits
	localparam int ND_AW    = 13;   // node store address bits
	localparam int STK_AW   = 5;    // stack address bits
	localparam int STK_LW   = 6;    // stack level bits (holds the depth)
	localparam int CRD_W    = 24;
	localparam int SQ_W     = 52;
	localparam int BUDGET_W = 15;
	localparam logic [BUDGET_W-1:0] BUDGET_INIT = 15'd16383 + 15'd1;
	localparam logic [STK_LW-1:0]   STACK_DEPTH = 6'd32;

	localparam logic [2:0] OP_LOAD_POINT = 3'd0;
	localparam logic [2:0] OP_LOAD_INDEX = 3'd1;
	localparam logic [2:0] OP_LOAD_NODE  = 3'd2;
	localparam logic [2:0] OP_BEGIN      = 3'd3;
	localparam logic [2:0] OP_NEXT       = 3'd4;

	localparam logic CFG_RADIUS = 1'b0;
	localparam logic CFG_POINTS = 1'b1;

	typedef struct packed {
		logic [2:0]         operation;
		logic [12:0]        slot;
		logic signed [23:0] coord_x;
		logic signed [23:0] coord_y;
		logic signed [23:0] coord_z;
		logic [11:0]        point_number;
		logic               node_is_leaf;
		logic [11:0]        node_start;
		logic [12:0]        node_size;
		logic [1:0]         node_split_dim;
		logic signed [23:0] node_split_value;
		logic [12:0]        node_first_child;
	} req_t;

	typedef struct packed {
		logic [12:0] neighbor;
		logic        search_done;
	} rsp_t;

	// node shape word
	typedef struct packed {
		logic        leaf;
		logic [11:0] start;
		logic [12:0] size;
		logic [1:0]  dim;
		logic [12:0] child;
	} node_t;

	typedef struct packed {
		logic [13:0]     node;
		logic [SQ_W-1:0] off;
	} stk_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} qitem_t;

endpackage

### rtl/kdr_front.sv
// ----------------------------------------------------------------------------
// kdr_front: request intake
// Drops unknown operations and queues the rest in a two-entry FIFO while it is not full.
// ----------------------------------------------------------------------------
module kdr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  kdr_pkg::req_t req,
	output kdr_pkg::qitem_t head,
	input  logic          pop
);

	kdr_pkg::req_t fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, known;

	assign busy  = (count_q == 2'd2);
	assign known = (req.operation <= kdr_pkg::OP_NEXT);
	assign push  = start && !busy && known;

	assign head.valid = (count_q != 2'd0);
	assign head.req   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop && head.valid)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop && head.valid);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push) else $error("fifo overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("pop from empty fifo");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("fifo count out of range");
`endif

endmodule

### rtl/kdr_engine.sv
// ----------------------------------------------------------------------------
// kdr_engine: store owner and search sequencer
// Executes loads into the stores and walks leaf scans and the node stack.
// ----------------------------------------------------------------------------
module kdr_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  kdr_pkg::qitem_t head,
	output logic            pop,
	input  logic            cfg_we,
	input  logic            cfg_idx,
	input  logic [51:0]     cfg_data,
	output logic            result_valid,
	output kdr_pkg::rsp_t   result
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_Q0    = 4'd1;
	localparam logic [3:0] S_Q1    = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_IDX   = 4'd4;
	localparam logic [3:0] S_PT    = 4'd5;
	localparam logic [3:0] S_SQ    = 4'd6;
	localparam logic [3:0] S_SUM   = 4'd7;
	localparam logic [3:0] S_POP   = 4'd8;
	localparam logic [3:0] S_NODE  = 4'd9;
	localparam logic [3:0] S_NSQ   = 4'd10;
	localparam logic [3:0] S_PUSH1 = 4'd11;
	localparam logic [3:0] S_PUSH2 = 4'd12;

	logic [3:0]  state_q;
	logic [51:0] radius_q;
	logic [12:0] npts_q;
	logic [11:0] query_q, id_q;
	logic signed [23:0] qx_q, qy_q, qz_q;
	logic [13:0] cursor_q, limit_q;
	logic [5:0]  level_q;
	logic [14:0] budget_q;
	logic [51:0] off_q;
	logic [24:0] mx_q, my_q, mz_q;
	logic [48:0] sx_q, sy_q, sz_q, nsq_q;
	logic signed [24:0] ndiff_q;
	logic [12:0] child_q;
	logic        result_valid_q;
	kdr_pkg::rsp_t result_q;

	// stores
	logic signed [23:0] px_mem [4096];
	logic signed [23:0] py_mem [4096];
	logic signed [23:0] pz_mem [4096];
	logic [11:0]        idx_mem [4096];
	kdr_pkg::node_t     node_mem [8192];
	logic signed [23:0] split_mem [8192];
	kdr_pkg::stk_t      stk_mem [32];

	logic signed [23:0] px_rd, py_rd, pz_rd, split_rd;
	logic [11:0]        idx_rd, pt_ra;
	kdr_pkg::node_t     node_rd;
	kdr_pkg::stk_t      stk_rd, stk_wd;
	logic [4:0]         stk_wa, stk_top;
	logic               stk_we;

	kdr_pkg::req_t r;
	logic is_load, ld_pt, ld_idx, ld_node, is_begin;

	assign r        = head.req;
	assign is_load  = (state_q == S_IDLE) && head.valid;
	assign ld_pt    = is_load && r.operation == kdr_pkg::OP_LOAD_POINT && !r.slot[12];
	assign ld_idx   = is_load && r.operation == kdr_pkg::OP_LOAD_INDEX && !r.slot[12];
	assign ld_node  = is_load && r.operation == kdr_pkg::OP_LOAD_NODE;
	assign is_begin = is_load && r.operation == kdr_pkg::OP_BEGIN;
	assign pop      = is_load;

	assign pt_ra   = (state_q == S_Q0) ? query_q : idx_rd;
	assign stk_top = 5'(level_q - 6'd1);

	always_ff @(posedge clk) begin
		if (ld_pt) begin
			px_mem[r.slot[11:0]] <= r.coord_x;
			py_mem[r.slot[11:0]] <= r.coord_y;
			pz_mem[r.slot[11:0]] <= r.coord_z;
		end
		px_rd <= px_mem[pt_ra];
		py_rd <= py_mem[pt_ra];
		pz_rd <= pz_mem[pt_ra];
	end

	always_ff @(posedge clk) begin
		if (ld_idx)
			idx_mem[r.slot[11:0]] <= r.point_number;
		idx_rd <= idx_mem[cursor_q[11:0]];
	end

	always_ff @(posedge clk) begin
		if (ld_node) begin
			node_mem[r.slot]  <= '{leaf: r.node_is_leaf, start: r.node_start,
				size: r.node_size, dim: r.node_split_dim, child: r.node_first_child};
			split_mem[r.slot] <= r.node_split_value;
		end
		node_rd  <= node_mem[stk_rd.node[12:0]];
		split_rd <= split_mem[stk_rd.node[12:0]];
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[stk_wa] <= stk_wd;
		stk_rd <= stk_mem[stk_top];
	end

	// split side: near child first, far child carries the offset
	logic [13:0] near_nd, far_nd;
	assign near_nd = ndiff_q[24] ? {1'b0, child_q} : 14'({1'b0, child_q} + 14'd1);
	assign far_nd  = ndiff_q[24] ? 14'({1'b0, child_q} + 14'd1) : {1'b0, child_q};

	always_comb begin
		stk_we = 1'b0;
		stk_wa = stk_top;
		stk_wd = '{node: near_nd, off: off_q};
		if (is_begin) begin
			stk_we = 1'b1;
			stk_wa = 5'd0;
			stk_wd = '0;
		end else if (state_q == S_PUSH1) begin
			stk_we = 1'b1;
			if (level_q < kdr_pkg::STACK_DEPTH)
				stk_wd = '{node: far_nd, off: {3'b000, nsq_q}};
		end else if (state_q == S_PUSH2) begin
			stk_we = 1'b1;
			stk_wa = level_q[4:0];
		end
	end

	logic signed [24:0] dx, dy, dz, ndiff;
	logic signed [23:0] qsel;
	logic [50:0] dsum;
	logic [24:0] nmag;

	assign dx   = 25'(qx_q) - 25'(px_rd);
	assign dy   = 25'(qy_q) - 25'(py_rd);
	assign dz   = 25'(qz_q) - 25'(pz_rd);
	assign qsel = (node_rd.dim == 2'd0) ? qx_q : (node_rd.dim == 2'd1) ? qy_q : qz_q;
	assign ndiff = 25'(qsel) - 25'(split_rd);
	assign nmag  = ndiff_q[24] ? 25'(-ndiff_q) : ndiff_q;
	assign dsum  = 51'(sx_q) + 51'(sy_q) + 51'(sz_q);

	always_ff @(posedge clk) begin
		case (state_q)
			S_Q1: begin
				qx_q <= px_rd;
				qy_q <= py_rd;
				qz_q <= pz_rd;
			end
			S_IDX: id_q <= idx_rd;
			S_PT: begin
				mx_q <= dx[24] ? 25'(-dx) : dx;
				my_q <= dy[24] ? 25'(-dy) : dy;
				mz_q <= dz[24] ? 25'(-dz) : dz;
			end
			S_SQ: begin
				sx_q <= 49'(mx_q * mx_q);
				sy_q <= 49'(my_q * my_q);
				sz_q <= 49'(mz_q * mz_q);
			end
			S_POP: off_q <= stk_rd.off;
			S_NODE: begin
				ndiff_q <= ndiff;
				child_q <= node_rd.child;
			end
			S_NSQ: nsq_q <= 49'(nmag * nmag);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			radius_q       <= '0;
			npts_q         <= '0;
			query_q        <= '0;
			cursor_q       <= '0;
			limit_q        <= '0;
			level_q        <= '0;
			budget_q       <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == kdr_pkg::CFG_RADIUS)
					radius_q <= cfg_data;
				else
					npts_q <= cfg_data[12:0];
			end
			case (state_q)
				S_IDLE: begin
					if (head.valid && (r.operation == kdr_pkg::OP_BEGIN
							|| r.operation == kdr_pkg::OP_NEXT)) begin
						if (r.operation == kdr_pkg::OP_BEGIN) begin
							query_q  <= r.point_number;
							level_q  <= 6'd1;
							cursor_q <= '0;
							limit_q  <= '0;
						end
						budget_q <= kdr_pkg::BUDGET_INIT;
						state_q  <= S_Q0;
					end
				end
				S_Q0: state_q <= S_Q1;
				S_Q1: state_q <= S_SCAN;
				S_SCAN: begin
					if (cursor_q < limit_q) begin
						cursor_q <= cursor_q + 14'd1;
						// positions beyond the index store are skipped
						if (cursor_q[13:12] == 2'b00)
							state_q <= S_IDX;
					end else if (level_q == 6'd0 || budget_q == '0) begin
						level_q        <= '0;
						cursor_q       <= limit_q;
						result_valid_q <= 1'b1;
						result_q       <= '{neighbor: npts_q, search_done: 1'b1};
						state_q        <= S_IDLE;
					end else begin
						state_q <= S_POP;
					end
				end
				S_IDX: state_q <= (idx_rd == query_q) ? S_SCAN : S_PT;
				S_PT:  state_q <= S_SQ;
				S_SQ:  state_q <= S_SUM;
				S_SUM: begin
					if ({1'b0, dsum} < radius_q) begin
						result_valid_q <= 1'b1;
						result_q       <= '{neighbor: {1'b0, id_q}, search_done: 1'b0};
						state_q        <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_POP: begin
					budget_q <= budget_q - 15'd1;
					if (stk_rd.node[13] || stk_rd.off >= radius_q) begin
						level_q <= level_q - 6'd1;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_NODE;
					end
				end
				S_NODE: begin
					if (node_rd.leaf) begin
						level_q  <= level_q - 6'd1;
						cursor_q <= {2'b00, node_rd.start};
						limit_q  <= 14'({2'b00, node_rd.start}) + 14'({1'b0, node_rd.size});
						state_q  <= S_SCAN;
					end else begin
						state_q <= S_NSQ;
					end
				end
				S_NSQ: state_q <= S_PUSH1;
				S_PUSH1: state_q <= (level_q < kdr_pkg::STACK_DEPTH) ? S_PUSH2 : S_SCAN;
				S_PUSH2: begin
					level_q <= level_q + 6'd1;
					state_q <= S_SCAN;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= kdr_pkg::STACK_DEPTH) else $error("stack level overflow");
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("back to back result strobes");
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.search_done |-> level_q == 6'd0)
		else $error("search done with non-empty stack");
`endif

endmodule

### rtl/kd_tree_radius_neighbor_search.sv
// Sequence: a load request is taken by the engine in its idle state; a begin or next request
// reads the query point, then scans leaf positions, pops and prunes stack entries, enters
// leaves, splits inner nodes and finally reports when the search is done.
// Flow: the engine works on one request at a time and a two-entry queue accepts ahead.
// The result cannot stall.
// Reset: asynchronous, empty stack, zero control registers; stores hold nothing until loaded.
// ----------------------------------------------------------------------------
// kd_tree_radius_neighbor_search: fixed-radius neighbour search top level
// Front queue feeding the search engine.
// ----------------------------------------------------------------------------
module kd_tree_radius_neighbor_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  kdr_pkg::req_t req,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic [51:0]   cfg_data,
	output logic          result_valid,
	output kdr_pkg::rsp_t result
);

	kdr_pkg::qitem_t head;
	logic            pop;

	kdr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.head   (head),
		.pop    (pop)
	);

	kdr_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
